/* design/ohr_pkg.sv */
// Shared types, widths, codes and defaults of the onset grid histogram rhythm block.
package ohr_pkg;

    localparam int TIME_W   = 48;
    localparam int LAT_W    = 16;
    localparam int W_W      = 17;
    localparam int PROD_W   = 2 * W_W - 1;
    localparam int Q_FRAC   = 16;
    localparam int PAT_W    = 4;
    localparam int CNT_W    = 3;
    localparam int STAT_W   = 2;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 4;

    localparam int RING_DEPTH_DEF    = 128;
    localparam int SUBDIVISIONS_DEF  = 4;
    localparam int BEATS_PER_BAR_DEF = 4;

    localparam logic [W_W-1:0]   ONE_Q16  = W_W'(65536);
    localparam logic [W_W-1:0]   HALF_Q16 = W_W'(32768);

    localparam logic [LAT_W-1:0] LATENCY_RST = '0;
    localparam logic [W_W-1:0]   DECAY_RST   = W_W'(49152);
    localparam logic             INVERT_RST  = 1'b1;

    localparam logic [1:0] REG_LATENCY = 2'd0;
    localparam logic [1:0] REG_DECAY   = 2'd1;
    localparam logic [1:0] REG_INVERT  = 2'd2;

    localparam logic ACT_ONSET = 1'b0;
    localparam logic ACT_BEAT  = 1'b1;

    localparam logic [STAT_W-1:0] STATUS_GEN        = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_SKIP_DUR   = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_SKIP_FIRST = 2'd2;

    typedef struct packed {
        logic              action;
        logic [TIME_W-1:0] event_time;
    } t_in_word;

    typedef struct packed {
        logic [PAT_W-1:0]  onset_pattern;
        logic [CNT_W-1:0]  onset_count;
        logic [STAT_W-1:0] beat_status;
    } t_out_word;

    typedef struct packed {
        logic [LAT_W-1:0] latency_adjust;
        logic [W_W-1:0]   decay_factor;
        logic             invert_mode;
    } t_cfg;

    typedef struct packed {
        logic init;
        logic step;
    } t_thr_ctl;

endpackage

/* design/ohr_ram.sv */
// Generic single-port-write, registered-read RAM.
module ohr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/ohr_cfg.sv */
// APB register bank: latency adjust, decay factor and invert mode.
module ohr_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ohr_pkg::APB_AW-1:0]    paddr,
    input  logic [ohr_pkg::APB_DW-1:0]    pwdata,
    output logic [ohr_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    output ohr_pkg::t_cfg                 o_cfg
);

    import ohr_pkg::*;

    t_cfg           r_cfg;
    logic           wr_en;
    logic [W_W-1:0] decay_in;

    assign wr_en    = psel && penable && pwrite;
    assign decay_in = pwdata[W_W-1:0];
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.latency_adjust <= LATENCY_RST;
            r_cfg.decay_factor   <= DECAY_RST;
            r_cfg.invert_mode    <= INVERT_RST;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_LATENCY: r_cfg.latency_adjust <= pwdata[LAT_W-1:0];
                // Factors above 1.0 saturate to 1.0.
                REG_DECAY:   r_cfg.decay_factor <= (decay_in > ONE_Q16) ? ONE_Q16 : decay_in;
                REG_INVERT:  r_cfg.invert_mode <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_LATENCY: prdata = APB_DW'(r_cfg.latency_adjust);
            REG_DECAY:   prdata = APB_DW'(r_cfg.decay_factor);
            REG_INVERT:  prdata = APB_DW'(r_cfg.invert_mode);
            default:     prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

/* design/ohr_quant.sv */
// Grid quantizer: builds slot thresholds for a beat and classifies stored onsets.
module ohr_quant #(
    parameter int SUBDIVISIONS = ohr_pkg::SUBDIVISIONS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ohr_pkg::t_thr_ctl           i_ctl,
    input  logic [ohr_pkg::TIME_W-1:0]  i_prev,
    input  logic [ohr_pkg::TIME_W-1:0]  i_dur,
    input  logic [ohr_pkg::TIME_W-1:0]  i_sample,
    output logic [SUBDIVISIONS-1:0]     o_hit,
    output logic                        o_brk,
    output logic                        o_last
);

    import ohr_pkg::*;

    localparam int TWO_S = 2 * SUBDIVISIONS;
    localparam int SC_W  = TIME_W + $clog2(TWO_S) + 2;
    localparam int K_W   = $clog2(SUBDIVISIONS + 1);

    // Threshold k is (2k-1)*D + 2S*prev, so 2S*onset is compared directly.
    logic signed [SC_W-1:0] r_thr [SUBDIVISIONS+1];
    logic signed [SC_W-1:0] r_acc;
    logic signed [SC_W-1:0] r_dur2;
    logic [K_W-1:0]         r_k;
    logic signed [SC_W-1:0] init_val;
    logic signed [SC_W-1:0] scaled;
    logic [SUBDIVISIONS:0]  ge;

    assign init_val = $signed(SC_W'(i_prev) * SC_W'(TWO_S)) - $signed(SC_W'(i_dur));
    assign scaled   = $signed(SC_W'(i_sample) * SC_W'(TWO_S));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
        end else if (i_ctl.init) begin
            r_k    <= '0;
            r_acc  <= init_val;
            r_dur2 <= $signed(SC_W'(i_dur) << 1);
        end else if (i_ctl.step) begin
            r_thr[r_k] <= r_acc;
            r_acc      <= r_acc + r_dur2;
            r_k        <= r_k + K_W'(1);
        end
    end

    assign o_last = i_ctl.step && (r_k == K_W'(SUBDIVISIONS));

    // The lowest threshold is strict: exactly half a slot before the beat rounds away to -1.
    always_comb begin
        ge[0] = scaled > r_thr[0];
        for (int k = 1; k <= SUBDIVISIONS; k++) begin
            ge[k] = scaled >= r_thr[k];
        end
        for (int q = 0; q < SUBDIVISIONS; q++) begin
            o_hit[q] = ge[q] && !ge[q+1];
        end
    end

    assign o_brk = ge[SUBDIVISIONS];

endmodule

/* design/onset_grid_histogram_rhythm.sv */
// Onset grid histogram rhythm generator, top level.
//
// An onset word is stored, latency corrected, in the onset ring memory; a full ring
// drops its oldest entry. A beat word that is skipped (time not past the previous beat,
// or the first beat) writes its status word straight to the output register. Any other
// beat occupies the block while the slot thresholds are built with one adder, the drain
// walks the ring memory at one entry per cycle until it stops, and each slot of the
// histogram memory is then read, multiplied and written back, after which each slot is
// read again for the next beat's weights. The ring's read port sets the drain rate. The
// result word waits in an output register; onset words are still taken while it waits.
module onset_grid_histogram_rhythm #(
    parameter int RING_DEPTH    = ohr_pkg::RING_DEPTH_DEF,
    parameter int SUBDIVISIONS  = ohr_pkg::SUBDIVISIONS_DEF,
    parameter int BEATS_PER_BAR = ohr_pkg::BEATS_PER_BAR_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ohr_pkg::APB_AW-1:0]   paddr,
    input  logic [ohr_pkg::APB_DW-1:0]   pwdata,
    output logic [ohr_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  ohr_pkg::t_in_word            i_in,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output ohr_pkg::t_out_word           o_out
);

    import ohr_pkg::*;

    localparam int RING_AW  = $clog2(RING_DEPTH);
    localparam int RCNT_W   = $clog2(RING_DEPTH + 1);
    localparam int HIST_LEN = SUBDIVISIONS * BEATS_PER_BAR;
    localparam int HIST_AW  = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1;
    localparam int BAR_W    = (BEATS_PER_BAR > 1) ? $clog2(BEATS_PER_BAR) : 1;
    localparam int SLOT_W   = (SUBDIVISIONS > 1) ? $clog2(SUBDIVISIONS) : 1;

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SUBDIVISIONS - 1);
    localparam logic [BAR_W-1:0]  BAR_LAST  = BAR_W'(BEATS_PER_BAR - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_THR,
        ST_DRAIN,
        ST_WRD,
        ST_WMUL,
        ST_WWR,
        ST_PRD,
        ST_PCHK
    } t_state;

    t_state              r_state;
    logic [RING_AW-1:0]  r_head, n_head;
    logic [RING_AW-1:0]  r_tail, n_tail;
    logic [RCNT_W-1:0]   r_count, n_count;
    logic [TIME_W-1:0]   r_last;
    logic [BAR_W-1:0]    r_bar;
    logic [SLOT_W-1:0]   r_slot;
    logic [SUBDIVISIONS-1:0] r_mask;
    logic                r_mbit;
    logic [PROD_W-1:0]   r_prod;
    logic [PAT_W-1:0]    r_pat;
    logic                r_wrd_ok;
    logic                r_wvalid [HIST_LEN];
    logic                r_out_valid;
    t_out_word           r_out;

    t_cfg                cfg;
    t_thr_ctl            thr_ctl;
    logic                accept;
    logic                beat_go;
    logic                ring_we;
    logic [TIME_W-1:0]   onset_time;
    logic [TIME_W-1:0]   lat_ext;
    logic [TIME_W-1:0]   ring_rdata;
    logic [TIME_W-1:0]   beat_dur;
    logic [SUBDIVISIONS-1:0] q_hit;
    logic                q_brk;
    logic                q_last;
    logic [HIST_AW-1:0]  w_addr;
    logic [W_W-1:0]      w_rdata;
    logic [W_W-1:0]      w_old;
    logic [PROD_W:0]     round_sum;
    logic [W_W-1:0]      leak;
    logic [W_W-1:0]      boost;
    logic [W_W-1:0]      w_new;
    logic                play;
    logic [PAT_W-1:0]    pat_now;
    logic [CNT_W-1:0]    pat_count;

    function automatic logic [RING_AW-1:0] ring_next(input logic [RING_AW-1:0] ptr);
        ring_next = (ptr == RING_AW'(RING_DEPTH - 1)) ? '0 : ptr + RING_AW'(1);
    endfunction

    ohr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // A beat that must wait for the output register is held off; onsets are not.
    assign o_in_ready = (r_state == ST_IDLE) &&
                        (!r_out_valid || i_out_ready || (i_in.action == ACT_ONSET));
    assign accept     = i_in_valid && o_in_ready;
    assign beat_go    = (i_in.event_time > r_last) && (r_last != '0);
    assign beat_dur   = i_in.event_time - r_last;

    assign lat_ext    = TIME_W'(cfg.latency_adjust);
    assign onset_time = (i_in.event_time > lat_ext) ? i_in.event_time - lat_ext
                                                    : i_in.event_time;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        ring_we = 1'b0;
        thr_ctl = '0;
        if (accept && (i_in.action == ACT_ONSET)) begin
            ring_we = 1'b1;
            n_tail  = ring_next(r_tail);
            if (r_count == RCNT_W'(RING_DEPTH)) begin
                n_head = ring_next(r_head);
            end else begin
                n_count = r_count + RCNT_W'(1);
            end
        end
        if (accept && (i_in.action == ACT_BEAT) && beat_go) begin
            thr_ctl.init = 1'b1;
        end
        if (r_state == ST_THR) begin
            thr_ctl.step = 1'b1;
        end
        if ((r_state == ST_DRAIN) && (r_count != '0) && !q_brk) begin
            n_head  = ring_next(r_head);
            n_count = r_count - RCNT_W'(1);
        end
    end

    // The ring is read at the next head every cycle, so its data matches r_head unless an onset was just written there.
    ohr_ram #(
        .WIDTH (TIME_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_tail),
        .i_wdata (onset_time),
        .i_re    (1'b1),
        .i_raddr (n_head),
        .o_rdata (ring_rdata)
    );

    ohr_quant #(
        .SUBDIVISIONS (SUBDIVISIONS)
    ) u_quant (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (thr_ctl),
        .i_prev   (r_last),
        .i_dur    (beat_dur),
        .i_sample (ring_rdata),
        .o_hit    (q_hit),
        .o_brk    (q_brk),
        .o_last   (q_last)
    );

    // The bar position advances between the update pass and the pattern pass.
    assign w_addr = HIST_AW'(32'(r_bar) * SUBDIVISIONS + 32'(r_slot));

    ohr_ram #(
        .WIDTH (W_W),
        .DEPTH (HIST_LEN)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (r_state == ST_WWR),
        .i_waddr (w_addr),
        .i_wdata (w_new),
        .i_re    ((r_state == ST_WRD) || (r_state == ST_PRD)),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    // Entries never written read as zero weight.
    assign w_old     = r_wrd_ok ? w_rdata : '0;
    assign round_sum = {1'b0, r_prod} + (PROD_W + 1)'(HALF_Q16);
    assign leak      = W_W'(round_sum >> Q_FRAC);
    assign boost     = r_mbit ? (ONE_Q16 - cfg.decay_factor) : '0;
    assign w_new     = leak + boost;

    assign play = (w_old >= HALF_Q16) ^ cfg.invert_mode;

    always_comb begin
        pat_now = r_pat;
        for (int j = 0; j < PAT_W; j++) begin
            if (32'(r_slot) == j) begin
                pat_now[j] = play;
            end
        end
        pat_count = '0;
        for (int j = 0; j < PAT_W; j++) begin
            pat_count = pat_count + CNT_W'(pat_now[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_last      <= '0;
            r_bar       <= '0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < HIST_LEN; i++) begin
                r_wvalid[i] <= 1'b0;
            end
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept && (i_in.action == ACT_BEAT)) begin
                        r_mask <= '0;
                        r_pat  <= '0;
                        r_slot <= '0;
                        if (i_in.event_time <= r_last) begin
                            r_out_valid <= 1'b1;
                            r_out       <= '{onset_pattern: '0, onset_count: '0,
                                             beat_status: STATUS_SKIP_DUR};
                        end else begin
                            r_last <= i_in.event_time;
                            if (r_last == '0) begin
                                r_out_valid <= 1'b1;
                                r_out       <= '{onset_pattern: '0, onset_count: '0,
                                                 beat_status: STATUS_SKIP_FIRST};
                            end else begin
                                r_state <= ST_THR;
                            end
                        end
                    end
                end
                ST_THR: begin
                    if (q_last) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    // An onset at or past the next beat's first slot stays in the ring.
                    if ((r_count == '0) || q_brk) begin
                        r_state <= ST_WRD;
                    end else begin
                        r_mask <= r_mask | q_hit;
                    end
                end
                ST_WRD: begin
                    r_wrd_ok <= r_wvalid[w_addr];
                    r_mbit   <= r_mask[r_slot];
                    r_state  <= ST_WMUL;
                end
                ST_WMUL: begin
                    r_prod  <= PROD_W'((2 * W_W)'(w_old) * (2 * W_W)'(cfg.decay_factor));
                    r_state <= ST_WWR;
                end
                ST_WWR: begin
                    r_wvalid[w_addr] <= 1'b1;
                    if (r_slot == SLOT_LAST) begin
                        r_slot  <= '0;
                        r_bar   <= (r_bar == BAR_LAST) ? '0 : r_bar + BAR_W'(1);
                        r_state <= ST_PRD;
                    end else begin
                        r_slot  <= r_slot + SLOT_W'(1);
                        r_state <= ST_WRD;
                    end
                end
                ST_PRD: begin
                    r_wrd_ok <= r_wvalid[w_addr];
                    r_state  <= ST_PCHK;
                end
                ST_PCHK: begin
                    r_pat <= pat_now;
                    if (r_slot == SLOT_LAST) begin
                        r_out_valid <= 1'b1;
                        r_out       <= '{onset_pattern: pat_now, onset_count: pat_count,
                                         beat_status: STATUS_GEN};
                        r_state     <= ST_IDLE;
                    end else begin
                        r_slot  <= r_slot + SLOT_W'(1);
                        r_state <= ST_PRD;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
